// ===== design/tm_pkg.sv =====
`timescale 1ns / 1ps

package tm_pkg;

  // default fraction bits of the quantised curve coefficients
  localparam int FRAC_BITS_DEFAULT = 16;

  // channel widths
  localparam int IN_W   = 32;
  localparam int X_W    = 21;              // clamped input, 0 .. 16.0 in Q16.16
  localparam int X_FRAC = 16;
  localparam int OUT_W  = 17;              // unsigned Q1.16
  localparam int QUO_W  = 16;              // quotient bits from the divider cells
  localparam int P_W    = 30;              // a*x+b and c*x+d at 24 fraction bits
  localparam int P_FRAC = 24;
  localparam int ND_FRAC = 40;             // numerator / denominator fraction bits
  localparam int ND_W   = 51;              // numerator and denominator
  localparam int REM_W  = ND_W + 1;        // partial remainder after the shift
  localparam int CHANNELS = 3;

  localparam logic [X_W-1:0]   X_MAX   = X_W'(16) << X_FRAC;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << QUO_W;

  // coefficient hundredths: k = h / 100, rounded to nearest at frac fraction bits
  localparam int H_A = 251;
  localparam int H_B = 3;
  localparam int H_C = 243;
  localparam int H_D = 59;
  localparam int H_E = 14;

  function automatic longint unsigned coef(input int hundredths, input int frac);
    longint unsigned scaled;
    scaled = longint'(hundredths) << frac;
    return (scaled + 64'd50) / 64'd100;
  endfunction

  // one channel as it moves through the divider chain
  typedef struct packed {
    logic              sat;                // curve at or above 1.0
    logic [ND_W-1:0]   den;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } tm_div_t;

endpackage

// ===== design/aces_filmic_tonemap.sv =====
`timescale 1ns / 1ps

// Filmic tone curve for linear HDR RGB pixels, one pixel per transaction.
// Slave channel s_*: s_tdata carries red, green, blue as signed Q16.16.
// Master channel m_*: m_tdata carries red, green, blue as unsigned Q1.16,
// 65536 standing for 1.0; negative channels give 0.
// From an accepted input to m_tvalid a pixel passes three front
// stages (clamp and linear terms, the two products, saturation test) and
// sixteen divider cells, each of which resolves one quotient bit.
// Throughput is one pixel per clock while m_tready stays high; every stage
// and cell holds one pixel and hands it on to its neighbor when it has room.
// When m_tready is low the last cell holds its pixel and stages behind it
// fill up one by one; s_tready stays high while any stage has room, so
// input keeps flowing into empty slots of the chain.
// Synchronous reset clears all valid flags; the pipeline comes up empty
// and ready at once, with no pixel in flight.
module aces_filmic_tonemap #(
  parameter int FRAC_BITS = tm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // red_in[31:0], green_in[63:32], blue_in[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // red_out[16:0], green_out[33:17], blue_out[50:34], zero
);

  localparam int CELLS = tm_pkg::QUO_W;

  logic [tm_pkg::CHANNELS-1:0][tm_pkg::IN_W-1:0] in_chan;
  logic [CELLS:0]                                link_valid;
  logic [CELLS:0]                                link_ready;
  tm_pkg::tm_div_t [tm_pkg::CHANNELS-1:0]        link_data [CELLS+1];
  logic [tm_pkg::CHANNELS-1:0][tm_pkg::OUT_W-1:0] out_chan;

  assign in_chan = s_tdata;

  // clamp, products and saturation test
  tm_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_chan   (in_chan),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  assign link_ready[CELLS] = m_tready;
  assign m_tvalid          = link_valid[CELLS];

  // saturated channels read as exactly 1.0
  always_comb begin
    for (int c = 0; c < tm_pkg::CHANNELS; c++) begin
      out_chan[c] = link_data[CELLS][c].sat ? tm_pkg::OUT_ONE
                                            : tm_pkg::OUT_W'(link_data[CELLS][c].quo);
    end
  end

  assign m_tdata = {5'b0, out_chan};

endmodule

// ===== design/tm_front.sv =====
`timescale 1ns / 1ps

module tm_front #(
  parameter int FRAC_BITS = tm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [tm_pkg::CHANNELS-1:0][tm_pkg::IN_W-1:0] in_chan,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output tm_pkg::tm_div_t [tm_pkg::CHANNELS-1:0]   out_data
);

  localparam int COEF_W = FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + tm_pkg::X_W + 1;
  localparam int P_SHIFT = FRAC_BITS - (tm_pkg::P_FRAC - tm_pkg::X_FRAC);
  localparam int E_SHIFT = tm_pkg::ND_FRAC - FRAC_BITS;
  localparam logic [COEF_W-1:0] KA = COEF_W'(tm_pkg::coef(tm_pkg::H_A, FRAC_BITS));
  localparam logic [COEF_W-1:0] KB = COEF_W'(tm_pkg::coef(tm_pkg::H_B, FRAC_BITS));
  localparam logic [COEF_W-1:0] KC = COEF_W'(tm_pkg::coef(tm_pkg::H_C, FRAC_BITS));
  localparam logic [COEF_W-1:0] KD = COEF_W'(tm_pkg::coef(tm_pkg::H_D, FRAC_BITS));
  localparam logic [COEF_W-1:0] KE = COEF_W'(tm_pkg::coef(tm_pkg::H_E, FRAC_BITS));

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // each stage moves when empty or when the next one takes its transaction
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  for (genvar c = 0; c < tm_pkg::CHANNELS; c++) begin : g_chan
    logic [tm_pkg::X_W-1:0]  x_clamp;
    logic [PROD_W-1:0]       sum_p, sum_q;
    logic [tm_pkg::X_W-1:0]  x1;
    logic [tm_pkg::P_W-1:0]  p1, q1;
    logic [tm_pkg::ND_W-1:0] num_c, den_c, num2, den2;
    tm_pkg::tm_div_t         seed;

    // clamp below at zero and above at 16.0
    always_comb begin
      if (in_chan[c][tm_pkg::IN_W-1]) begin
        x_clamp = '0;
      end else if (in_chan[c] > tm_pkg::IN_W'(tm_pkg::X_MAX)) begin
        x_clamp = tm_pkg::X_MAX;
      end else begin
        x_clamp = in_chan[c][tm_pkg::X_W-1:0];
      end
    end

    // linear terms a*x+b and c*x+d
    assign sum_p = PROD_W'(KA) * PROD_W'(x_clamp) + (PROD_W'(KB) << tm_pkg::X_FRAC);
    assign sum_q = PROD_W'(KC) * PROD_W'(x_clamp) + (PROD_W'(KD) << tm_pkg::X_FRAC);

    always_ff @(posedge clk) begin
      if (rdy1) begin
        x1 <= x_clamp;
        p1 <= tm_pkg::P_W'(sum_p >> P_SHIFT);
        q1 <= tm_pkg::P_W'(sum_q >> P_SHIFT);
      end
    end

    // numerator and denominator at 40 fraction bits
    assign num_c = tm_pkg::ND_W'(p1) * tm_pkg::ND_W'(x1);
    assign den_c = tm_pkg::ND_W'(q1) * tm_pkg::ND_W'(x1)
                 + (tm_pkg::ND_W'(KE) << E_SHIFT);

    always_ff @(posedge clk) begin
      if (rdy2) begin
        num2 <= num_c;
        den2 <= den_c;
      end
    end

    // saturation test and divider seed
    always_ff @(posedge clk) begin
      if (rdy3) begin
        seed.sat <= (num2 >= den2);
        seed.den <= den2;
        seed.rem <= tm_pkg::REM_W'(num2);
        seed.quo <= '0;
      end
    end

    assign out_data[c] = seed;
  end

endmodule

// ===== design/tm_div_cell.sv =====
`timescale 1ns / 1ps

module tm_div_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  tm_pkg::tm_div_t [tm_pkg::CHANNELS-1:0] in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tm_pkg::tm_div_t [tm_pkg::CHANNELS-1:0] out_data
);

  tm_pkg::tm_div_t [tm_pkg::CHANNELS-1:0] step;

  assign in_ready = !out_valid || out_ready;

  // one restoring division step per channel
  always_comb begin
    for (int c = 0; c < tm_pkg::CHANNELS; c++) begin
      logic [tm_pkg::REM_W-1:0] shifted;
      logic [tm_pkg::REM_W-1:0] den_ext;
      logic                     take;
      shifted = {in_data[c].rem[tm_pkg::REM_W-2:0], 1'b0};
      den_ext = tm_pkg::REM_W'(in_data[c].den);
      take    = (shifted >= den_ext);
      step[c].sat = in_data[c].sat;
      step[c].den = in_data[c].den;
      step[c].rem = take ? (shifted - den_ext) : shifted;
      step[c].quo = {in_data[c].quo[tm_pkg::QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= step;
    end
  end

endmodule
